// ----- rtl/pl0_pkg.sv -----
package pl0_pkg;
  localparam int REG_COUNT = 10;
  localparam int STACK_DEPTH = 128;
  localparam int RA_W = $clog2(REG_COUNT);
  localparam int SA_W = $clog2(STACK_DEPTH);

  localparam logic [4:0] OP_LIT = 5'd1;
  localparam logic [4:0] OP_RET = 5'd2;
  localparam logic [4:0] OP_LOD = 5'd3;
  localparam logic [4:0] OP_STO = 5'd4;
  localparam logic [4:0] OP_CAL = 5'd5;
  localparam logic [4:0] OP_INC = 5'd6;
  localparam logic [4:0] OP_JMP = 5'd7;
  localparam logic [4:0] OP_JPC = 5'd8;
  localparam logic [4:0] OP_WRT = 5'd9;
  localparam logic [4:0] OP_RED = 5'd10;
  localparam logic [4:0] OP_HLT = 5'd11;
  localparam logic [4:0] OP_NEG = 5'd12;
  localparam logic [4:0] OP_ADD = 5'd13;
  localparam logic [4:0] OP_SUB = 5'd14;
  localparam logic [4:0] OP_MUL = 5'd15;
  localparam logic [4:0] OP_DIV = 5'd16;
  localparam logic [4:0] OP_MOD = 5'd17;
  localparam logic [4:0] OP_EQL = 5'd18;
  localparam logic [4:0] OP_NEQ = 5'd19;
  localparam logic [4:0] OP_LSS = 5'd20;
  localparam logic [4:0] OP_LEQ = 5'd21;
  localparam logic [4:0] OP_GTR = 5'd22;
  localparam logic [4:0] OP_GEQ = 5'd23;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVF = 2'd1;
  localparam logic [1:0] ERR_OOB = 2'd2;
  localparam logic [1:0] ERR_DIV0 = 2'd3;

  typedef struct packed {
    logic [4:0] opcode;
    logic [3:0] reg_r;
    logic [3:0] level;
    logic [15:0] operand_m;
    logic signed [31:0] input_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic write_valid;
    logic signed [31:0] write_value;
    logic halted;
    logic [1:0] error_code;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // latch instruction, start
    logic rd_rf;     // read RF[sel] into operand
    logic [1:0] rf_sel; // 0 r, 1 l, 2 m
    logic rd_stk;    // issue stack read
    logic [1:0] stk_sel; // 0 chain, 1 fb-1, 2 fb-2, 3 ea
    logic chain_step;  // take stack data as new chain base
    logic cap_a;     // capture stack data in tmp a
    logic div_start;
    logic div_step;
    logic exec;      // commit result
    logic [1:0] cal_wr; // 1..3 write CAL words
    logic fault;     // chain link bad
  } cmd_t;

  typedef struct packed {
    logic [4:0] opcode;
    logic halted;
    logic [3:0] lvl;
    logic link_bad;
    logic div_busy;
  } sts_t;
endpackage

// ----- rtl/pl0_if.sv -----
interface pl0_in_if;
  pl0_pkg::in_item_t data;
  logic valid;
  logic ready;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface pl0_out_if;
  pl0_pkg::out_item_t data;
  logic valid;
  logic ready;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/pl0_ram.sv -----
module pl0_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/pl0_div.sv -----
module pl0_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic busy,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  logic [31:0] q_r, r_r, d_r;
  logic [5:0] cnt_r;
  logic na_r, nb_r;
  logic [32:0] trial;
  logic [31:0] rsh;
  always_comb begin
    rsh = {r_r[30:0], q_r[31]};
    trial = {1'b0, rsh} - {1'b0, d_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'd32;
      q_r <= a[31] ? -a : a;
      d_r <= b[31] ? -b : b;
      r_r <= '0;
      na_r <= a[31];
      nb_r <= b[31];
    end else if (cnt_r != 0) begin
      cnt_r <= cnt_r - 6'd1;
      if (!trial[32]) begin
        r_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= rsh;
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end
  assign busy = cnt_r != 0;
  assign quo = (na_r ^ nb_r) ? -q_r : q_r;
  assign rem = na_r ? -r_r : r_r;
endmodule

// ----- rtl/pl0_ctrl.sv -----
module pl0_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  pl0_pkg::sts_t sts,
  output pl0_pkg::cmd_t cmd
);
  import pl0_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_RDR = 4'd1, S_RDL = 4'd2, S_RDM = 4'd3,
    S_CHAIN = 4'd4, S_CHW = 4'd5, S_RET1 = 4'd6, S_RET2 = 4'd7, S_RET3 = 4'd8,
    S_EA = 4'd9, S_EAW = 4'd10, S_DIV = 4'd11, S_EXEC = 4'd12, S_CAL2 = 4'd13,
    S_CAL3 = 4'd14, S_OUT = 4'd15;
  logic [3:0] st_r, st_nxt;
  logic [3:0] lv_r, lv_nxt;

  always_comb begin
    st_nxt = st_r;
    lv_nxt = lv_r;
    cmd = '0;
    in_ready = st_r == S_IDLE;
    out_valid = st_r == S_OUT;
    case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        st_nxt = S_RDR;
      end
      S_RDR: begin
        cmd.rd_rf = 1'b1;
        cmd.rf_sel = 2'd0;
        lv_nxt = sts.lvl;
        if (sts.halted) st_nxt = S_EXEC;
        else if (sts.opcode inside {[OP_ADD:OP_GEQ]}) st_nxt = S_RDL;
        else if (sts.opcode == OP_LOD || sts.opcode == OP_STO) st_nxt = S_RDM;
        else if (sts.opcode == OP_CAL) st_nxt = S_CHAIN;
        else if (sts.opcode == OP_RET) st_nxt = S_RET1;
        else st_nxt = S_EXEC;
      end
      S_RDL: begin
        cmd.rd_rf = 1'b1;
        cmd.rf_sel = 2'd1;
        st_nxt = S_RDM;
      end
      S_RDM: begin
        cmd.rd_rf = 1'b1;
        cmd.rf_sel = 2'd2;
        if (sts.opcode == OP_DIV || sts.opcode == OP_MOD) begin
          cmd.div_start = 1'b1;
          st_nxt = S_DIV;
        end else if (sts.opcode inside {[OP_ADD:OP_GEQ]}) st_nxt = S_EXEC;
        else st_nxt = S_CHAIN;
      end
      S_CHAIN: begin
        // walk the static chain one link per pass through S_CHAIN and S_CHW
        if (lv_r == 0) st_nxt = (sts.opcode == OP_CAL) ? S_EXEC : S_EA;
        else begin
          cmd.rd_stk = 1'b1;
          cmd.stk_sel = 2'd0;
          st_nxt = S_CHW;
        end
      end
      S_CHW: begin
        cmd.chain_step = 1'b1;
        if (sts.link_bad) begin
          cmd.fault = 1'b1;
          st_nxt = S_EXEC;
        end else begin
          lv_nxt = lv_r - 4'd1;
          st_nxt = S_CHAIN;
        end
      end
      S_RET1: begin
        cmd.rd_stk = 1'b1;
        cmd.stk_sel = 2'd1;
        st_nxt = S_RET2;
      end
      S_RET2: begin
        cmd.cap_a = 1'b1;
        cmd.rd_stk = 1'b1;
        cmd.stk_sel = 2'd2;
        st_nxt = S_RET3;
      end
      S_RET3: begin
        // hold the return-address read so it is still there at exec
        cmd.rd_stk = 1'b1;
        cmd.stk_sel = 2'd2;
        st_nxt = S_EXEC;
      end
      S_EA: begin
        cmd.rd_stk = 1'b1;
        cmd.stk_sel = 2'd3;
        st_nxt = S_EAW;
      end
      S_EAW: begin
        cmd.rd_stk = 1'b1;
        cmd.stk_sel = 2'd3;
        st_nxt = S_EXEC;
      end
      S_DIV: if (!sts.div_busy) st_nxt = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.cal_wr = 2'd1;
        st_nxt = (sts.opcode == OP_CAL) ? S_CAL2 : S_OUT;
      end
      S_CAL2: begin
        cmd.cal_wr = 2'd2;
        st_nxt = S_CAL3;
      end
      S_CAL3: begin
        cmd.cal_wr = 2'd3;
        st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      lv_r <= '0;
    end else begin
      st_r <= st_nxt;
      lv_r <= lv_nxt;
    end
  end

  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output both open");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> st_r == S_RDR) else $error("load lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ----- rtl/pl0_dp.sv -----
module pl0_dp (
  input  logic clk,
  input  logic rst_n,
  input  pl0_pkg::in_item_t in_data,
  input  pl0_pkg::cmd_t cmd,
  output pl0_pkg::sts_t sts,
  output pl0_pkg::out_item_t out_data
);
  import pl0_pkg::*;
  logic [31:0] rf_r [REG_COUNT];
  logic [STACK_DEPTH-1:0] sv_r;  // stack entry valid
  in_item_t ir_r;
  logic [31:0] vr_r, vl_r, vm_r, a_r;
  logic [7:0] fb_r, sp_r, cb_r;
  logic [15:0] pc_r;
  logic halt_r, fault_r;
  out_item_t res_r;

  logic [SA_W-1:0] raddr, waddr;
  logic [31:0] rdraw, sdata, wdata;
  logic we;
  logic [SA_W-1:0] raddr_q;
  logic [31:0] rfo;
  logic [3:0] rsel;
  logic [31:0] quo, rem;
  logic dbusy;

  pl0_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdraw));
  pl0_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .a(vl_r), .b(rfo),
    .busy(dbusy), .quo(quo), .rem(rem));

  assign sdata = sv_r[raddr_q] ? rdraw : 32'd0;

  always_comb begin
    case (cmd.rf_sel)
      2'd0: rsel = ir_r.reg_r;
      2'd1: rsel = ir_r.level;
      default: rsel = ir_r.operand_m[3:0];
    endcase
    rfo = (32'(rsel) < REG_COUNT) ? rf_r[rsel[RA_W-1:0]] : 32'd0;
  end

  // effective address for LOD/STO
  logic signed [33:0] ea;
  assign ea = $signed({26'd0, cb_r}) - $signed({{2{vm_r[31]}}, vm_r});

  always_comb begin
    case (cmd.stk_sel)
      2'd0: raddr = cb_r[SA_W-1:0];
      2'd1: raddr = SA_W'(fb_r - 8'd1);
      2'd2: raddr = SA_W'(fb_r - 8'd2);
      default: raddr = ea[SA_W-1:0];
    endcase
  end

  logic r_ok, l_ok, m_ok, ea_ok;
  assign r_ok = 32'(ir_r.reg_r) < REG_COUNT;
  assign l_ok = 32'(ir_r.level) < REG_COUNT;
  assign m_ok = 32'(ir_r.operand_m) < REG_COUNT;
  assign ea_ok = !ea[33] && (ea < 34'(STACK_DEPTH));

  // execute decision
  logic [1:0] err;
  logic [15:0] pc1, npc;
  logic rf_we;
  logic [31:0] rf_wd;
  logic st_we;
  logic [7:0] fb_n, sp_n;
  logic halt_n, wv;
  logic signed [31:0] sx, sy;
  always_comb begin
    sx = vl_r;
    sy = vm_r;
    pc1 = pc_r + 16'd1;
    npc = pc1;
    err = ERR_NONE;
    rf_we = 1'b0;
    rf_wd = '0;
    st_we = 1'b0;
    fb_n = fb_r;
    sp_n = sp_r;
    halt_n = halt_r;
    wv = 1'b0;
    case (ir_r.opcode)
      OP_LIT: if (!r_ok) err = ERR_OOB; else begin
        rf_we = 1'b1; rf_wd = {16'd0, ir_r.operand_m};
      end
      OP_RET: if (fb_r < 8'd2 || a_r >= 32'(STACK_DEPTH) || sdata > 32'hFFFF) err = ERR_OOB;
        else begin
          sp_n = fb_r + 8'd1; fb_n = a_r[7:0]; npc = sdata[15:0];
        end
      OP_LOD, OP_STO: if (!r_ok || !m_ok || fault_r || !ea_ok) err = ERR_OOB;
        else if (ir_r.opcode == OP_LOD) begin
          rf_we = 1'b1; rf_wd = sdata;
        end else st_we = 1'b1;
      OP_CAL: if (fault_r) err = ERR_OOB; else if (sp_r < 8'd3) err = ERR_OVF;
        else begin
          fb_n = sp_r - 8'd1; npc = ir_r.operand_m;
        end
      OP_INC: if (17'(ir_r.operand_m) > 17'(sp_r)) err = ERR_OVF;
        else sp_n = sp_r - ir_r.operand_m[7:0];
      OP_JMP: npc = ir_r.operand_m;
      OP_JPC: if (!r_ok) err = ERR_OOB; else if (vr_r == 0) npc = ir_r.operand_m;
      OP_WRT: if (!r_ok) err = ERR_OOB; else wv = 1'b1;
      OP_RED: if (!r_ok) err = ERR_OOB; else begin
        rf_we = 1'b1; rf_wd = ir_r.input_value;
      end
      OP_HLT: halt_n = 1'b1;
      OP_NEG: if (!r_ok) err = ERR_OOB; else begin
        rf_we = 1'b1; rf_wd = -vr_r;
      end
      default: if (ir_r.opcode inside {[OP_ADD:OP_GEQ]}) begin
        if (!r_ok || !l_ok || !m_ok) err = ERR_OOB;
        else if ((ir_r.opcode == OP_DIV || ir_r.opcode == OP_MOD) && vm_r == 0)
          err = ERR_DIV0;
        else begin
          rf_we = 1'b1;
          case (ir_r.opcode)
            OP_ADD: rf_wd = vl_r + vm_r;
            OP_SUB: rf_wd = vl_r - vm_r;
            OP_MUL: rf_wd = vl_r * vm_r;
            OP_DIV: rf_wd = quo;
            OP_MOD: rf_wd = rem;
            OP_EQL: rf_wd = {31'd0, sx == sy};
            OP_NEQ: rf_wd = {31'd0, sx != sy};
            OP_LSS: rf_wd = {31'd0, sx < sy};
            OP_LEQ: rf_wd = {31'd0, sx <= sy};
            OP_GTR: rf_wd = {31'd0, sx > sy};
            default: rf_wd = {31'd0, sx >= sy};
          endcase
        end
      end
    endcase
    if (err != ERR_NONE) begin
      halt_n = 1'b1; rf_we = 1'b0; st_we = 1'b0; fb_n = fb_r; sp_n = sp_r;
      npc = pc1; wv = 1'b0;
    end
  end

  // stack writes: STO at exec, CAL frame words at exec and at cal_wr 2 and 3
  logic cal_ok_r;
  logic [7:0] osp_r, ofb_r;
  logic [15:0] rpc_r;
  always_comb begin
    we = 1'b0;
    waddr = ea[SA_W-1:0];
    wdata = vr_r;
    if (cmd.exec && !halt_r && st_we) we = 1'b1;
    // static link goes in at exec, the other two words follow
    if (cmd.exec && !halt_r && ir_r.opcode == OP_CAL && err == ERR_NONE) begin
      we = 1'b1; waddr = SA_W'(sp_r - 8'd1); wdata = {24'd0, cb_r};
    end
    if (cal_ok_r && cmd.cal_wr == 2'd2) begin
      we = 1'b1; waddr = SA_W'(osp_r - 8'd2); wdata = {24'd0, ofb_r};
    end
    if (cal_ok_r && cmd.cal_wr == 2'd3) begin
      we = 1'b1; waddr = SA_W'(osp_r - 8'd3); wdata = {16'd0, rpc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= '0;
      sv_r <= '0;
      fb_r <= 8'(STACK_DEPTH - 1);
      sp_r <= 8'(STACK_DEPTH);
      pc_r <= '0;
      halt_r <= 1'b0;
      cal_ok_r <= 1'b0;
    end else begin
      raddr_q <= raddr;
      if (cmd.load) begin
        ir_r <= in_data;
        cb_r <= fb_r;
        fault_r <= 1'b0;
      end
      if (cmd.rd_rf) begin
        case (cmd.rf_sel)
          2'd0: vr_r <= rfo;
          2'd1: vl_r <= rfo;
          default: vm_r <= rfo;
        endcase
      end
      if (cmd.chain_step && !sts.link_bad) cb_r <= sdata[7:0];
      if (cmd.fault) fault_r <= 1'b1;
      if (cmd.cap_a) a_r <= sdata;
      if (we) sv_r[waddr] <= 1'b1;
      if (cmd.exec) begin
        cal_ok_r <= 1'b0;
        if (halt_r) begin
          res_r <= '{next_pc: pc_r, write_valid: 1'b0, write_value: '0,
                     halted: 1'b1, error_code: ERR_NONE};
        end else begin
          pc_r <= npc;
          halt_r <= halt_n;
          fb_r <= fb_n;
          sp_r <= sp_n;
          if (rf_we) rf_r[ir_r.reg_r[RA_W-1:0]] <= rf_wd;
          res_r <= '{next_pc: npc, write_valid: wv, write_value: wv ? vr_r : 32'd0,
                     halted: halt_n, error_code: err};
          if (ir_r.opcode == OP_CAL && err == ERR_NONE) begin
            cal_ok_r <= 1'b1;
            osp_r <= sp_r; ofb_r <= fb_r; rpc_r <= pc1;
          end
        end
      end
    end
  end

  assign sts.opcode = ir_r.opcode;
  assign sts.halted = halt_r;
  assign sts.lvl = ir_r.level;
  assign sts.link_bad = sdata >= 32'(STACK_DEPTH);
  assign sts.div_busy = dbusy;
  assign out_data = res_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= STACK_DEPTH) else $error("stack top out of range");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared");
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !halt_r && err == ERR_DIV0) |-> vm_r == 0) else $error("bad div0");
endmodule

// ----- rtl/pl0_register_vm_execute_top.sv -----
// PL/0 register machine execute unit.
// in channel carries one instruction (opcode, reg_r, level, operand_m,
// input_value); out channel returns one result per instruction with next_pc,
// the WRT value, the halt state and the error code of that step.
// Instructions run one at a time: in_ready is high only while idle.
// Path through the controller: LIT, JMP, WRT and the other single-register
// ops read r and go to exec; ALU ops also read l and m, DIV/MOD then wait
// on the one-bit-per-cycle divider; RET reads two stack words; LOD/STO
// read m, walk the static chain one link per level and read the stack word;
// CAL walks the chain and writes its three frame words. in_ready returns
// the cycle after the result transaction.
// The stack lives in a single-port-write RAM; a valid bit per entry makes
// never-written words read as zero.
// Reset (rst_n low, synchronous) clears registers, stack valid bits, sets
// frame base to depth-1, stack top to depth, PC to zero, halt off.
// When the receiver stalls, the result is held on out and no new
// instruction is taken until it is accepted.
// Once halted, each instruction returns the held PC with halted set.
module pl0_register_vm_execute_top (
  input logic clk,
  input logic rst_n,
  pl0_in_if.sink in_ch,
  pl0_out_if.source out_ch
);
  import pl0_pkg::*;
  cmd_t cmd;
  sts_t sts;
  pl0_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd));
  pl0_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_ch.data), .cmd(cmd), .sts(sts),
    .out_data(out_ch.data));
endmodule
